// File: hw/rtl/aoqt_pkg.sv
// ----------------------------------------------------------------------------
// aoqt_pkg
// Shared types and codes for the box table with overlap query.
// ----------------------------------------------------------------------------
package aoqt_pkg;

	localparam int CAPACITY_DEF   = 32;
	localparam int COORD_BITS_DEF = 16;
	localparam int ID_W           = 16;
	localparam int KIND_W         = 2;
	localparam int STAT_W         = 2;
	localparam int OUT_USER_W     = STAT_W + 1;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_RUN
	} st_t;

	// broadcast controls for the cell row
	typedef struct packed {
		logic load;   // capture compare flag
		logic query;  // flag means overlap hit, else id match
		logic pick;   // lowest flagged cell drops its flag
		logic shift;  // cells at or above the first flag take their upper neighbor
	} cell_ctrl_t;

endpackage

// File: hw/rtl/aabb_overlap_query_table.sv
// ----------------------------------------------------------------------------
// aabb_overlap_query_table
// Insert, remove, clear and overlap query on a row of box cells.
// Insert and clear results are issued from the EVAL state; remove results and
// query beats from the RUN state after it. One item at a time: the next item
// is accepted only after the last result beat is issued. A query gives one
// beat per cycle in slot order while the sink is ready, or one no-match beat.
// Reset empties the table; stored boxes are not cleared.
// ----------------------------------------------------------------------------
module aabb_overlap_query_table #(
	parameter int CAPACITY   = aoqt_pkg::CAPACITY_DEF,
	parameter int COORD_BITS = aoqt_pkg::COORD_BITS_DEF,
	parameter int S_DATA_W   = ((aoqt_pkg::ID_W + 6*COORD_BITS + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// object_id, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, zero pad
	input  logic [S_DATA_W-1:0]               s_tdata,
	// kind
	input  logic [aoqt_pkg::KIND_W-1:0]       s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// hit_id
	output logic [aoqt_pkg::ID_W-1:0]         m_tdata,
	// status, match_valid
	output logic [aoqt_pkg::OUT_USER_W-1:0]   m_tuser,
	output logic                              m_tlast
);
	import aoqt_pkg::*;

	localparam int BOX_W = 6*COORD_BITS;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	st_t              state_q, state_d;
	logic [KIND_W-1:0] kind_q;
	logic [ID_W-1:0]  id_q;
	logic [BOX_W-1:0] box_q;
	logic [CNT_W-1:0] count_q;

	logic                  out_free;
	logic                  emit;
	logic [STAT_W-1:0]     e_status;
	logic                  e_match;
	logic [ID_W-1:0]       e_id;
	logic                  e_last;
	logic                  write_en;
	logic                  cnt_inc, cnt_dec, cnt_clr;
	cell_ctrl_t            ctrl;

	logic [CAPACITY:0]     below;
	logic [CAPACITY-1:0]   flag;
	logic [CAPACITY-1:0]   sel;
	logic [ID_W-1:0]       cell_id [CAPACITY];
	logic [BOX_W-1:0]      cell_box [CAPACITY];
	logic [ID_W-1:0]       nb_id [CAPACITY];
	logic [BOX_W-1:0]      nb_box [CAPACITY];
	logic [ID_W-1:0]       pick_id;
	logic                  more;
	logic                  any_flag;
	logic                  full;

	logic                  m_tvalid_q;
	logic [ID_W-1:0]       m_tdata_q;
	logic [OUT_USER_W-1:0] m_tuser_q;
	logic                  m_tlast_q;

	assign s_tready = (state_q == ST_IDLE);
	assign out_free = ~m_tvalid_q | m_tready;
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign below[0] = 1'b0;
	assign any_flag = below[CAPACITY];

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			if (g == CAPACITY - 1) begin : g_top
				assign nb_id[g]  = cell_id[g];
				assign nb_box[g] = cell_box[g];
			end else begin : g_mid
				assign nb_id[g]  = cell_id[g+1];
				assign nb_box[g] = cell_box[g+1];
			end
			aoqt_cell #(
				.COORD_BITS(COORD_BITS)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.live     (CNT_W'(g) < count_q),
				.wr_sel   (write_en && (CNT_W'(g) == count_q)),
				.q_id     (id_q),
				.q_box    (box_q),
				.nb_id    (nb_id[g]),
				.nb_box   (nb_box[g]),
				.below_in (below[g]),
				.below_out(below[g+1]),
				.flag     (flag[g]),
				.sel      (sel[g]),
				.id       (cell_id[g]),
				.box      (cell_box[g])
			);
		end
	endgenerate

	// lowest hit id; more = a second flag exists above some flag
	always_comb begin
		pick_id = '0;
		more    = 1'b0;
		for (int i = 0; i < CAPACITY; i++) begin
			pick_id = pick_id | (sel[i] ? cell_id[i] : '0);
			more    = more | (flag[i] & below[i]);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (kind_q inside {KIND_REMOVE, KIND_QUERY}) begin
					state_d = ST_RUN;
				end else if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_RUN: begin
				if (out_free && !(kind_q == KIND_QUERY && any_flag && more)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		emit       = 1'b0;
		e_status   = STAT_OK;
		e_match    = 1'b0;
		e_id       = '0;
		e_last     = 1'b1;
		write_en   = 1'b0;
		cnt_inc    = 1'b0;
		cnt_dec    = 1'b0;
		cnt_clr    = 1'b0;
		ctrl       = '0;
		ctrl.query = (kind_q == KIND_QUERY);
		case (state_q)
			ST_EVAL: begin
				ctrl.load = 1'b1;
				if (out_free) begin
					case (kind_q)
						KIND_INSERT: begin
							emit = 1'b1;
							if (full) begin
								e_status = STAT_FULL;
							end else begin
								write_en = 1'b1;
								cnt_inc  = 1'b1;
							end
						end
						KIND_CLEAR: begin
							emit    = 1'b1;
							cnt_clr = 1'b1;
						end
						default: ;
					endcase
				end
			end
			ST_RUN: begin
				if (out_free) begin
					emit = 1'b1;
					if (kind_q == KIND_QUERY) begin
						if (any_flag) begin
							e_match   = 1'b1;
							e_id      = pick_id;
							e_last    = ~more;
							ctrl.pick = 1'b1;
						end
					end else if (any_flag) begin
						ctrl.shift = 1'b1;
						cnt_dec    = 1'b1;
					end else begin
						e_status = STAT_NOT_FOUND;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (cnt_clr) begin
				count_q <= '0;
			end else if (cnt_inc) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cnt_dec) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_q <= s_tuser;
			id_q   <= s_tdata[ID_W-1:0];
			box_q  <= s_tdata[ID_W +: BOX_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata_q <= e_id;
			m_tuser_q <= {e_match, e_status};
			m_tlast_q <= e_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

// File: hw/rtl/aoqt_cell.sv
// ----------------------------------------------------------------------------
// aoqt_cell
// One table slot: stored id and box, overlap / id compare, hit flag, and the
// priority link to its neighbors.
// ----------------------------------------------------------------------------
module aoqt_cell #(
	parameter int COORD_BITS = aoqt_pkg::COORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  aoqt_pkg::cell_ctrl_t        ctrl,
	input  logic                        live,
	input  logic                        wr_sel,
	input  logic [aoqt_pkg::ID_W-1:0]   q_id,
	input  logic [6*COORD_BITS-1:0]     q_box,
	input  logic [aoqt_pkg::ID_W-1:0]   nb_id,
	input  logic [6*COORD_BITS-1:0]     nb_box,
	input  logic                        below_in,
	output logic                        below_out,
	output logic                        flag,
	output logic                        sel,
	output logic [aoqt_pkg::ID_W-1:0]   id,
	output logic [6*COORD_BITS-1:0]     box
);
	import aoqt_pkg::*;

	localparam int CB = COORD_BITS;

	logic [ID_W-1:0]   id_q;
	logic [6*CB-1:0]   box_q;
	logic              flag_q;
	logic              ovl;
	logic              hit_now;

	// box layout, low to high: lo_x lo_y lo_z hi_x hi_y hi_z
	always_comb begin
		ovl = 1'b1;
		for (int ax = 0; ax < 3; ax++) begin
			if ($signed(box_q[ax*CB +: CB]) > $signed(q_box[(ax+3)*CB +: CB]) ||
			    $signed(q_box[ax*CB +: CB]) > $signed(box_q[(ax+3)*CB +: CB])) begin
				ovl = 1'b0;
			end
		end
	end

	always_comb begin
		if (ctrl.query) begin
			hit_now = live && (id_q != q_id) && ovl;
		end else begin
			hit_now = live && (id_q == q_id);
		end
	end

	assign flag      = flag_q;
	assign below_out = below_in | flag_q;
	assign sel       = flag_q & ~below_in;
	assign id        = id_q;
	assign box       = box_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
		end else if (ctrl.load) begin
			flag_q <= hit_now;
		end else if (ctrl.pick && sel) begin
			flag_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_sel) begin
			id_q  <= q_id;
			box_q <= q_box;
		end else if (ctrl.shift && below_out) begin
			id_q  <= nb_id;
			box_q <= nb_box;
		end
	end

endmodule

// File: hw/rtl/aoqt_checker.sv
// ----------------------------------------------------------------------------
// aoqt_checker
// Port-level checks for the box table, bound to the top level.
// ----------------------------------------------------------------------------
module aoqt_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [aoqt_pkg::ID_W-1:0]         m_tdata,
	input logic [aoqt_pkg::OUT_USER_W-1:0]   m_tuser,
	input logic                              m_tlast
);
	import aoqt_pkg::*;

	// stalled beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
		$stable(m_tlast))
		else $error("output beat changed while stalled");

	// one item in flight
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while item in flight");

	a_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[STAT_W] |-> m_tdata == '0 && m_tlast)
		else $error("non-match beat with id or not last");

	a_err_beat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[STAT_W-1:0] != STAT_OK |-> !m_tuser[STAT_W] && m_tlast)
		else $error("error status on a match beat");

endmodule

bind aabb_overlap_query_table aoqt_checker u_aoqt_checker (.*);

// File: tb/sv/tb_aabb_overlap_query_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aabb_overlap_query_table
// Self-checking bench for the box table with overlap query. A directed table
// and a table fill run first. Random command streams follow, mostly on small
// boxes near the origin so that queries hit often. Both stream sides get
// random gaps and stalls. Every result beat is checked against an in-bench
// model of the table.
// ----------------------------------------------------------------------------
module tb_aabb_overlap_query_table;
	import aoqt_pkg::*;

	localparam int     CAP         = CAPACITY_DEF;
	localparam int     DATA_W      = ((ID_W + 6*COORD_BITS_DEF + 7) / 8) * 8;
	localparam int     RAND_ITEMS  = 424;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ID_W-1:0]   id;
		logic [2:0][15:0]  lo;   // x, y, z
		logic [2:0][15:0]  hi;
	} cmd_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic              match;
		logic [ID_W-1:0]   hit_id;
		logic              last;
	} beat_t;

	typedef struct packed {
		cmd_t  c;
		bit    typed;
		beat_t want;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [DATA_W-1:0]     s_tdata;
	logic [KIND_W-1:0]     s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [ID_W-1:0]       m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;
	logic                  m_tlast;

	// table model
	logic [ID_W-1:0]  tbl_id [CAP];
	logic [2:0][15:0] tbl_lo [CAP];
	logic [2:0][15:0] tbl_hi [CAP];
	int               tbl_count;

	beat_t    pending_beats [$];
	dir_row_t dir_tab [$];
	beat_t    mon_exp;
	int       errors;
	longint   cycle_cnt;
	bit       calm;
	bit       heavy;
	int       rx_left;
	int       rx_pick;
	bit       rx_on;

	aabb_overlap_query_table uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // object_id, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z
		.s_tuser  (s_tuser),   // kind
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // hit_id
		.m_tuser  (m_tuser),   // status, match_valid
		.m_tlast  (m_tlast)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit boxes_touch(input logic [2:0][15:0] alo, input logic [2:0][15:0] ahi,
	                                   input logic [2:0][15:0] blo, input logic [2:0][15:0] bhi);
		for (int ax = 0; ax < 3; ax++) begin
			if ($signed(alo[ax]) > $signed(bhi[ax]) || $signed(blo[ax]) > $signed(ahi[ax]))
				return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic beat_enq(input beat_t b);
		pending_beats = {pending_beats, b};
	endtask

	task automatic table_apply(input cmd_t c);
		int    slot;
		bit    have_prev;
		beat_t b;
		beat_t prev;
		b = '{status: STAT_OK, match: 1'b0, hit_id: '0, last: 1'b1};
		prev = b;
		have_prev = 1'b0;
		case (c.kind)
			KIND_INSERT: begin
				if (tbl_count >= CAP) begin
					b.status = STAT_FULL;
				end else begin
					tbl_id[tbl_count] = c.id;
					tbl_lo[tbl_count] = c.lo;
					tbl_hi[tbl_count] = c.hi;
					tbl_count++;
				end
				beat_enq(b);
			end
			KIND_REMOVE: begin
				slot = 0;
				while (slot < tbl_count && tbl_id[slot] != c.id)
					slot++;
				if (slot == tbl_count) begin
					b.status = STAT_NOT_FOUND;
				end else begin
					for (int i = slot; i + 1 < tbl_count; i++) begin
						tbl_id[i] = tbl_id[i+1];
						tbl_lo[i] = tbl_lo[i+1];
						tbl_hi[i] = tbl_hi[i+1];
					end
					tbl_count--;
				end
				beat_enq(b);
			end
			KIND_CLEAR: begin
				tbl_count = 0;
				beat_enq(b);
			end
			default: begin
				for (int i = 0; i < tbl_count; i++) begin
					if (tbl_id[i] != c.id && boxes_touch(tbl_lo[i], tbl_hi[i], c.lo, c.hi)) begin
						if (have_prev)
							beat_enq(prev);
						prev = '{status: STAT_OK, match: 1'b1, hit_id: tbl_id[i], last: 1'b0};
						have_prev = 1'b1;
					end
				end
				if (have_prev) begin
					prev.last = 1'b1;
					beat_enq(prev);
				end else begin
					beat_enq(b);
				end
			end
		endcase
	endtask

	function automatic cmd_t mk_cmd(input logic [KIND_W-1:0] kind, input int id,
	                                input int lx, input int ly, input int lz,
	                                input int hx, input int hy, input int hz);
		cmd_t c;
		c.kind  = kind;
		c.id    = 16'(id);
		c.lo[0] = 16'(lx);
		c.lo[1] = 16'(ly);
		c.lo[2] = 16'(lz);
		c.hi[0] = 16'(hx);
		c.hi[1] = 16'(hy);
		c.hi[2] = 16'(hz);
		return c;
	endfunction

	task automatic add_row(input cmd_t c, input bit typed, input logic [STAT_W-1:0] st);
		dir_row_t r;
		r.c     = c;
		r.typed = typed;
		r.want  = '{status: st, match: 1'b0, hit_id: '0, last: 1'b1};
		dir_tab = {dir_tab, r};
	endtask

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic cmd_t rand_cmd(input bit fill_bias);
		cmd_t c;
		int   r;
		int   ctr;
		int   half;
		int   a;
		int   b;
		r = $urandom_range(0, 99);
		if (fill_bias)
			c.kind = (r < 80) ? KIND_INSERT : ((r < 90) ? KIND_REMOVE : KIND_QUERY);
		else if (r < 35)
			c.kind = KIND_INSERT;
		else if (r < 57)
			c.kind = KIND_REMOVE;
		else if (r < 97)
			c.kind = KIND_QUERY;
		else
			c.kind = KIND_CLEAR;
		if ($urandom_range(0, 4) == 0)
			c.id = 16'($urandom);
		else
			c.id = 16'($urandom_range(0, 15));
		if (c.kind == KIND_REMOVE && tbl_count > 0 && $urandom_range(0, 9) < 7)
			c.id = tbl_id[$urandom_range(0, tbl_count - 1)];
		r = $urandom_range(0, 99);
		for (int ax = 0; ax < 3; ax++) begin
			if (r < 10) begin
				c.lo[ax] = 16'($urandom);
				c.hi[ax] = 16'($urandom);
			end else if (r < 15) begin
				c.lo[ax] = 16'h8000;
				c.hi[ax] = 16'h7fff;
			end else begin
				ctr  = int'($urandom_range(0, 2047)) - 1024;
				half = $urandom_range(0, 600);
				a    = ctr - half;
				b    = ctr + half;
				if ($urandom_range(0, 19) == 0) begin
					c.lo[ax] = 16'(b);
					c.hi[ax] = 16'(a);
				end else begin
					c.lo[ax] = 16'(a);
					c.hi[ax] = 16'(b);
				end
			end
		end
		return c;
	endfunction

	task automatic send_cmd(input cmd_t c, input int gap, input bit typed, input beat_t want);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= c.kind;
		s_tdata  <= {c.hi, c.lo, c.id};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		table_apply(c);
		if (typed) begin
			void'(pending_beats.pop_back());
			beat_enq(want);
		end
	endtask

	// sink ready: bursts of ready, short stalls, rare long stalls
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_pick = $urandom_range(0, 99);
			if (calm) begin
				rx_on   = 1'b1;
				rx_left = 1;
			end else if (rx_pick < 60) begin
				rx_on   = 1'b1;
				rx_left = $urandom_range(1, 8);
			end else if (rx_pick < 95) begin
				rx_on   = 1'b0;
				rx_left = $urandom_range(1, 3);
			end else begin
				rx_on   = 1'b0;
				rx_left = $urandom_range(10, 40);
			end
		end
		rx_left  = rx_left - 1;
		m_tready <= rx_on;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_beats.size() == 0) begin
				$error("unexpected result beat: hit_id %0h", m_tdata);
				errors++;
			end else begin
				mon_exp = pending_beats.pop_front();
				if (m_tuser[STAT_W-1:0] !== mon_exp.status) begin
					$error("status: expected %0d, got %0d", mon_exp.status, m_tuser[STAT_W-1:0]);
					errors++;
				end
				if (m_tuser[STAT_W] !== mon_exp.match) begin
					$error("match_valid: expected %0d, got %0d", mon_exp.match, m_tuser[STAT_W]);
					errors++;
				end
				if (m_tdata !== mon_exp.hit_id) begin
					$error("hit_id: expected %0h, got %0h", mon_exp.hit_id, m_tdata);
					errors++;
				end
				if (m_tlast !== mon_exp.last) begin
					$error("last: expected %0d, got %0d", mon_exp.last, m_tlast);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = KIND_INSERT;
		m_tready  = 1'b0;
		tbl_count = 0;
		errors    = 0;
		cycle_cnt = 0;
		calm      = 1'b0;
		heavy     = 1'b0;
		rx_left   = 0;
		rx_on     = 1'b0;

		// empty table, bound extremes, duplicates, inverted boxes, self skip
		add_row(mk_cmd(KIND_QUERY, 0, -32768, -32768, -32768, 32767, 32767, 32767), 1, STAT_OK);
		add_row(mk_cmd(KIND_REMOVE, 5, 0, 0, 0, 0, 0, 0), 1, STAT_NOT_FOUND);
		add_row(mk_cmd(KIND_CLEAR, 65535, 21845, -21846, 4660, -1, 0, 32767), 1, STAT_OK);
		add_row(mk_cmd(KIND_INSERT, 1, -32768, -32768, -32768, 32767, 32767, 32767), 1, STAT_OK);
		add_row(mk_cmd(KIND_INSERT, 65535, 32767, 32767, 32767, 32767, 32767, 32767), 1, STAT_OK);
		add_row(mk_cmd(KIND_INSERT, 4660, -32768, -32768, -32768, -32768, -32768, -32768),
		        1, STAT_OK);
		add_row(mk_cmd(KIND_INSERT, 4660, -256, -256, -256, 256, 256, 256), 1, STAT_OK);
		add_row(mk_cmd(KIND_INSERT, 170, 100, 100, 100, -100, -100, -100), 1, STAT_OK);
		add_row(mk_cmd(KIND_QUERY, 0, -32768, -32768, -32768, 32767, 32767, 32767), 0, STAT_OK);
		add_row(mk_cmd(KIND_QUERY, 1, 32767, 32767, 32767, 32767, 32767, 32767), 0, STAT_OK);
		add_row(mk_cmd(KIND_QUERY, 4660, 0, 0, 0, 0, 0, 0), 0, STAT_OK);
		add_row(mk_cmd(KIND_QUERY, 0, -32768, -32768, -32768, -32768, -32768, -32768),
		        0, STAT_OK);
		add_row(mk_cmd(KIND_QUERY, 0, 10, 10, 10, -10, -10, -10), 0, STAT_OK);
		add_row(mk_cmd(KIND_REMOVE, 4660, 0, 0, 0, 0, 0, 0), 1, STAT_OK);
		add_row(mk_cmd(KIND_QUERY, 0, -300, -300, -300, 300, 300, 300), 0, STAT_OK);
		add_row(mk_cmd(KIND_REMOVE, 39321, 0, 0, 0, 0, 0, 0), 1, STAT_NOT_FOUND);
		add_row(mk_cmd(KIND_REMOVE, 65535, 0, 0, 0, 0, 0, 0), 1, STAT_OK);
		add_row(mk_cmd(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1, STAT_OK);
		add_row(mk_cmd(KIND_QUERY, 0, -32768, -32768, -32768, 32767, 32767, 32767), 1, STAT_OK);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i])
			send_cmd(dir_tab[i].c, pick_gap(), dir_tab[i].typed, dir_tab[i].want);

		// fill to capacity, overflow, then a query hitting every slot
		for (int i = 0; i < CAP + 2; i++)
			send_cmd(mk_cmd(KIND_INSERT, 256 + i, -i, -i, -i, i, i, i), pick_gap(),
			         i >= CAP, '{status: STAT_FULL, match: 1'b0, hit_id: '0, last: 1'b1});
		send_cmd(mk_cmd(KIND_QUERY, 65534, -32768, -32768, -32768, 32767, 32767, 32767),
		         pick_gap(), 1'b0, '0);
		send_cmd(mk_cmd(KIND_REMOVE, 256, 0, 0, 0, 0, 0, 0), pick_gap(), 1'b0, '0);
		send_cmd(mk_cmd(KIND_QUERY, 300, -5, -5, -5, 40, 40, 40), pick_gap(), 1'b0, '0);

		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % 40 == 0) begin
				calm  = ($urandom_range(0, 3) == 0);
				heavy = ($urandom_range(0, 2) == 0);
			end
			send_cmd(rand_cmd(heavy), pick_gap(), 1'b0, '0);
		end
		calm = 1'b0;

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: files.f
hw/rtl/aoqt_pkg.sv
hw/rtl/aoqt_cell.sv
hw/rtl/aabb_overlap_query_table.sv
hw/rtl/aoqt_checker.sv
tb/sv/tb_aabb_overlap_query_table.sv
